### rtl/core/bounded_double_ended_queue_unit_defines.svh
// assertion macros for the bounded deque unit
// expects clk and arst_n in the scope of each use
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bdq_pkg.sv
// shared types and constants for the bounded deque unit
// no dependencies
package bdq_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int WORD_W_DEF = 32;

	// fixed port field widths
	localparam int DATA_W      = 32;
	localparam int COUNT_W     = 5;
	localparam int S_TDATA_W   = 32;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 104;
	localparam int M_TUSER_W   = 1;
	localparam int M_TDATA_PAD = M_TDATA_W - 3 * DATA_W - COUNT_W;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} req_t;

	// per-cycle command to every cell of one chain; head is cell 0
	typedef enum logic [2:0] {
		CMD_HOLD        = 3'd0,
		CMD_INSERT_HEAD = 3'd1,
		CMD_REMOVE_HEAD = 3'd2,
		CMD_APPEND_TAIL = 3'd3,
		CMD_DROP_TAIL   = 3'd4
	} cell_cmd_t;

endpackage

### rtl/core/bounded_double_ended_queue_unit.sv
// a taken request passes stage 1, then the output register; the chains update as it is taken
// throughput: one request per cycle while the output does not stall; both cell chains update together
// and the result is built from the chain heads as the request moves to the output register
// a stalled output holds one result plus one pending request, then input ready drops
// reset (arst_n low, asynchronous) empties the deque and clears all valid flags; no clearing pass
// top level of the bounded deque unit; depends on bdq_pkg, bdq_chain and the defines header
module bounded_double_ended_queue_unit #(
	parameter int DEPTH  = bdq_pkg::DEPTH_DEF,
	parameter int WORD_W = bdq_pkg::WORD_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
	input  logic [bdq_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] pop_value, [63:32] front_value, [95:64] back_value, [100:96] entry_count, rest zero
	output logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [bdq_pkg::M_TUSER_W-1:0] m_tuser   // [0] ok
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// two mirrored chains: one keeps the front word at its head, the other the back word,
	// so both ends are read at a fixed cell and no word select over the store is needed

	bdq_pkg::req_t             req;
	logic                      accept;
	logic                      is_push;
	logic                      done;
	logic [WORD_W-1:0]         push_word;
	bdq_pkg::cell_cmd_t        f_cmd;
	bdq_pkg::cell_cmd_t        b_cmd;
	logic                      f_head_valid;
	logic [WORD_W-1:0]         f_head_word;
	logic                      f_full;
	logic                      b_head_valid;
	logic [WORD_W-1:0]         b_head_word;
	logic                      b_full;
	logic [bdq_pkg::DATA_W-1:0] front32;
	logic [bdq_pkg::DATA_W-1:0] back32;
	logic [bdq_pkg::DATA_W-1:0] f_head32;
	logic [bdq_pkg::DATA_W-1:0] b_head32;
	logic [bdq_pkg::DATA_W-1:0] pop_word;
	logic [bdq_pkg::COUNT_W-1:0] count5;
	logic                      adv;

	logic [CNT_W-1:0]           count_q;
	logic                       pend_s1_q;
	logic                       ok_s1;
	logic [bdq_pkg::DATA_W-1:0] pop_s1;
	logic                       m_tvalid_q;
	logic [bdq_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [bdq_pkg::M_TUSER_W-1:0] m_tuser_q;

	// field width adaptation between the 32-bit ports and the stored word
	if (WORD_W > bdq_pkg::DATA_W) begin : g_wide
		assign push_word = {{(WORD_W - bdq_pkg::DATA_W){1'b0}}, s_tdata[bdq_pkg::DATA_W-1:0]};
		assign f_head32  = f_head_word[bdq_pkg::DATA_W-1:0];
		assign b_head32  = b_head_word[bdq_pkg::DATA_W-1:0];
	end else if (WORD_W == bdq_pkg::DATA_W) begin : g_same
		assign push_word = s_tdata[WORD_W-1:0];
		assign f_head32  = f_head_word;
		assign b_head32  = b_head_word;
	end else begin : g_narrow
		assign push_word = s_tdata[WORD_W-1:0];
		assign f_head32  = {{(bdq_pkg::DATA_W - WORD_W){1'b0}}, f_head_word};
		assign b_head32  = {{(bdq_pkg::DATA_W - WORD_W){1'b0}}, b_head_word};
	end

	// entry count as reported, low five bits
	if (CNT_W >= bdq_pkg::COUNT_W) begin : g_cnt_wide
		assign count5 = count_q[bdq_pkg::COUNT_W-1:0];
	end else begin : g_cnt_narrow
		assign count5 = {{(bdq_pkg::COUNT_W - CNT_W){1'b0}}, count_q};
	end

	// ends read as zero when the deque is empty
	assign front32 = f_head_valid ? f_head32 : '0;
	assign back32  = b_head_valid ? b_head32 : '0;

	// input transaction and refusal check
	assign req     = bdq_pkg::req_t'(s_tuser[1:0]);
	assign accept  = s_tvalid && s_tready;
	assign is_push = (req == bdq_pkg::REQ_PUSH_FRONT) || (req == bdq_pkg::REQ_PUSH_BACK);
	assign done    = is_push ? !f_full : f_head_valid;

	// chain commands; the back chain sees every request mirrored
	always_comb begin
		f_cmd = bdq_pkg::CMD_HOLD;
		b_cmd = bdq_pkg::CMD_HOLD;
		if (accept && done) begin
			case (req)
				bdq_pkg::REQ_PUSH_FRONT: begin
					f_cmd = bdq_pkg::CMD_INSERT_HEAD;
					b_cmd = bdq_pkg::CMD_APPEND_TAIL;
				end
				bdq_pkg::REQ_PUSH_BACK: begin
					f_cmd = bdq_pkg::CMD_APPEND_TAIL;
					b_cmd = bdq_pkg::CMD_INSERT_HEAD;
				end
				bdq_pkg::REQ_POP_FRONT: begin
					f_cmd = bdq_pkg::CMD_REMOVE_HEAD;
					b_cmd = bdq_pkg::CMD_DROP_TAIL;
				end
				bdq_pkg::REQ_POP_BACK: begin
					f_cmd = bdq_pkg::CMD_DROP_TAIL;
					b_cmd = bdq_pkg::CMD_REMOVE_HEAD;
				end
				default: begin
					f_cmd = bdq_pkg::CMD_HOLD;
					b_cmd = bdq_pkg::CMD_HOLD;
				end
			endcase
		end
	end

	// popped word comes from the head of the matching chain
	always_comb begin
		pop_word = '0;
		if (done && !is_push) begin
			pop_word = (req == bdq_pkg::REQ_POP_FRONT) ? front32 : back32;
		end
	end

	bdq_chain #(
		.DEPTH  (DEPTH),
		.WORD_W (WORD_W)
	) u_front_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (f_cmd),
		.in_word    (push_word),
		.head_valid (f_head_valid),
		.head_word  (f_head_word),
		.full       (f_full)
	);

	bdq_chain #(
		.DEPTH  (DEPTH),
		.WORD_W (WORD_W)
	) u_back_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (b_cmd),
		.in_word    (push_word),
		.head_valid (b_head_valid),
		.head_word  (b_head_word),
		.full       (b_full)
	);

	// entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && done) begin
			if (is_push) count_q <= count_q + 1'b1;
			else count_q <= count_q - 1'b1;
		end
	end

	// stage 1 holds ok and the popped word while the chains settle
	assign adv      = pend_s1_q && (!m_tvalid_q || m_tready);
	assign s_tready = !pend_s1_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1_q <= 1'b0;
		end else if (accept) begin
			pend_s1_q <= 1'b1;
		end else if (adv) begin
			pend_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1  <= done;
			pop_s1 <= pop_word;
		end
	end

	// output register; ends and count are sampled from the state left by the pending request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {{bdq_pkg::M_TDATA_PAD{1'b0}}, count5, back32, front32, pop_s1};
			m_tuser_q <= ok_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks
	`include "bounded_double_ended_queue_unit_defines.svh"

	// the two chains always agree on empty and full
	`BDQ_ASSERT_NOW(a_chains_agree, 1'b1, (f_head_valid == b_head_valid) && (f_full == b_full), "chains disagree on occupancy")
	// the counter matches chain occupancy at both ends
	`BDQ_ASSERT_NOW(a_count_empty, 1'b1, (count_q == '0) == !f_head_valid, "count and empty flag disagree")
	`BDQ_ASSERT_NOW(a_count_full, 1'b1, (count_q == CNT_W'(DEPTH)) == f_full, "count and full flag disagree")
	// an accepted push that fits raises the count by one
	`BDQ_ASSERT_NEXT(a_push_count, accept && is_push && done, count_q == $past(count_q) + 1'b1, "push did not raise count")
	// a pending request moving on always yields a result in the next cycle
	`BDQ_ASSERT_NEXT(a_adv_result, adv, m_tvalid, "pending request produced no result")

endmodule

### rtl/core/bdq_cell.sv
// one storage cell of a deque chain: occupancy bit and word
// depends on bdq_pkg
module bdq_cell #(
	parameter int WORD_W = bdq_pkg::WORD_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bdq_pkg::cell_cmd_t cmd,
	input  logic [WORD_W-1:0]  in_word,
	input  logic               prev_valid,
	input  logic [WORD_W-1:0]  prev_word,
	input  logic               next_valid,
	input  logic [WORD_W-1:0]  next_word,
	output logic               valid,
	output logic [WORD_W-1:0]  word
);

	logic              valid_q;
	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd)
				bdq_pkg::CMD_INSERT_HEAD: valid_q <= prev_valid;
				bdq_pkg::CMD_REMOVE_HEAD: valid_q <= next_valid;
				bdq_pkg::CMD_APPEND_TAIL: begin
					if (!valid_q && prev_valid) valid_q <= 1'b1;
				end
				bdq_pkg::CMD_DROP_TAIL: begin
					if (valid_q && !next_valid) valid_q <= 1'b0;
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			bdq_pkg::CMD_INSERT_HEAD: word_q <= prev_word;
			bdq_pkg::CMD_REMOVE_HEAD: word_q <= next_word;
			bdq_pkg::CMD_APPEND_TAIL: begin
				if (!valid_q && prev_valid) word_q <= in_word;
			end
			default: word_q <= word_q;
		endcase
	end

	assign valid = valid_q;
	assign word  = word_q;

endmodule

### rtl/core/bdq_chain.sv
// row of deque cells, head at cell 0, each cell talking to its two neighbors
// depends on bdq_pkg and bdq_cell
module bdq_chain #(
	parameter int DEPTH  = bdq_pkg::DEPTH_DEF,
	parameter int WORD_W = bdq_pkg::WORD_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bdq_pkg::cell_cmd_t cmd,
	input  logic [WORD_W-1:0]  in_word,
	output logic               head_valid,
	output logic [WORD_W-1:0]  head_word,
	output logic               full
);

	logic [DEPTH-1:0]             valid;
	logic [DEPTH-1:0][WORD_W-1:0] word;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              pv;
		logic [WORD_W-1:0] pw;
		logic              nv;
		logic [WORD_W-1:0] nw;

		// head cell sees the incoming word as its left neighbor
		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pw = in_word;
		end else begin : g_mid
			assign pv = valid[i-1];
			assign pw = word[i-1];
		end

		// far end sees an empty neighbor
		if (i == DEPTH - 1) begin : g_end
			assign nv = 1'b0;
			assign nw = '0;
		end else begin : g_inner
			assign nv = valid[i+1];
			assign nw = word[i+1];
		end

		bdq_cell #(
			.WORD_W(WORD_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.in_word    (in_word),
			.prev_valid (pv),
			.prev_word  (pw),
			.next_valid (nv),
			.next_word  (nw),
			.valid      (valid[i]),
			.word       (word[i])
		);
	end

	assign head_valid = valid[0];
	assign head_word  = word[0];
	assign full       = valid[DEPTH-1];

endmodule

### test/bdq_result_checker.sv
// result checker for the bounded deque unit: mirrors the deque from the request stream
// and compares every result transaction against the mirror; depends on bdq_pkg
module bdq_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [bdq_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [bdq_pkg::M_TUSER_W-1:0] m_tuser,
	output int                            fail_count,
	output int                            outstanding,
	output int                            full_refusals,
	output int                            empty_refusals,
	output int                            result_count
);
	import bdq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic               ok;
		logic [DATA_W-1:0]  pop_value;
		logic [DATA_W-1:0]  front_value;
		logic [DATA_W-1:0]  back_value;
		logic [COUNT_W-1:0] entry_count;
	} deque_result_t;

	logic [DATA_W-1:0] word_mirror [DEPTH];
	int unsigned       front_pos  = 0;
	int unsigned       word_count = 0;
	deque_result_t     expected_results [$];
	int                n_fail = 0, n_pending = 0, n_full = 0, n_empty = 0, n_results = 0;

	assign fail_count     = n_fail;
	assign outstanding    = n_pending;
	assign full_refusals  = n_full;
	assign empty_refusals = n_empty;
	assign result_count   = n_results;

	// applies one request to the mirror and returns the result it should produce
	function automatic deque_result_t apply_request(req_t req, logic [DATA_W-1:0] word);
		deque_result_t r;
		r = '0;
		case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (word_count < DEPTH) begin
					if (req == REQ_PUSH_FRONT) begin
						front_pos = (front_pos + DEPTH - 1) % DEPTH;
						word_mirror[front_pos] = word;
					end else begin
						word_mirror[(front_pos + word_count) % DEPTH] = word;
					end
					word_count++;
					r.ok = 1'b1;
				end else begin
					n_full++;
				end
			end
			default: begin
				if (word_count > 0) begin
					if (req == REQ_POP_FRONT) begin
						r.pop_value = word_mirror[front_pos];
						front_pos = (front_pos + 1) % DEPTH;
					end else begin
						r.pop_value = word_mirror[(front_pos + word_count - 1) % DEPTH];
					end
					word_count--;
					r.ok = 1'b1;
				end else begin
					n_empty++;
				end
			end
		endcase
		if (word_count > 0) begin
			r.front_value = word_mirror[front_pos];
			r.back_value  = word_mirror[(front_pos + word_count - 1) % DEPTH];
		end
		r.entry_count = COUNT_W'(word_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want, got;
		logic [M_TDATA_PAD-1:0] pad;
		if (!arst_n) begin
			front_pos  = 0;
			word_count = 0;
			expected_results.delete();
			n_pending  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				got.ok          = m_tuser[0];
				got.pop_value   = m_tdata[0 +: DATA_W];
				got.front_value = m_tdata[DATA_W +: DATA_W];
				got.back_value  = m_tdata[2 * DATA_W +: DATA_W];
				got.entry_count = m_tdata[3 * DATA_W +: COUNT_W];
				pad             = m_tdata[M_TDATA_W-1 -: M_TDATA_PAD];
				if (expected_results.size() == 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("result %0d arrived with no request waiting", n_results);
				end else begin
					want = expected_results.pop_front();
					if (got != want || pad != '0) begin
						n_fail++;
						if (n_fail <= MAX_REPORTS)
							$display({"result %0d mismatch: expected ok=%0b pop=%h front=%h ",
								"back=%h count=%0d; got ok=%0b pop=%h front=%h back=%h ",
								"count=%0d pad=%h"}, n_results,
								want.ok, want.pop_value, want.front_value,
								want.back_value, want.entry_count,
								got.ok, got.pop_value, got.front_value,
								got.back_value, got.entry_count, pad);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_request(req_t'(s_tuser), s_tdata));
			n_pending = expected_results.size();
		end
	end

endmodule

### test/tb.sv
// testbench top for the bounded deque unit: clock, reset, request stimulus and verdict
// depends on bdq_pkg, bounded_double_ended_queue_unit and bdq_result_checker
module tb;
	import bdq_pkg::*;

	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1000;
	localparam int IDLE_PHASES  = 3;
	localparam int DRAIN_CYCLES = 8;         // a result passes through stage 1 and the output register after its request
	localparam int CYCLE_LIMIT  = 200000;    // far above the slowest legal run

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;    // [31:0] push_value
	logic [S_TUSER_W-1:0] s_tuser  = '0;    // [1:0] req_type
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;          // pop, front, back, count, zero pad
	logic [M_TUSER_W-1:0] m_tuser;          // [0] ok

	int fail_count, outstanding, full_refusals, empty_refusals, result_count;
	int tx_idle_pct = 27;                    // sender idle chance per cycle
	int rx_idle_pct = 75;                    // receiver stall chance per cycle
	int cycle_count = 0;
	int requests_sent = 0;

	bounded_double_ended_queue_unit i_dut (.*);
	bdq_result_checker i_checker (.*);

	always #6 clk = ~clk;

	// receiver side: stall at random by the current phase
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// offers one request, entered and left at a falling edge, with random idle cycles first
	task automatic send_request(req_t req, logic [S_TDATA_W-1:0] word);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom();          // junk while idle
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	// hold the request side quiet until every result is back
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [S_TDATA_W-1:0] extreme_words [5];
		logic [S_TDATA_W-1:0] word;
		req_t                 req;
		bit                   filling;
		bit                   pushing;
		int                   bias_left;

		extreme_words = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
			32'h0000_0001};
		filling   = 1'b0;
		bias_left = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// pops on an empty deque are refused
		send_request(REQ_POP_FRONT, $urandom());
		send_request(REQ_POP_BACK, $urandom());
		// fill from both ends; the first front push wraps the head below zero
		for (int i = 0; i < DEPTH_DEF; i++) begin
			word = (i < 5) ? extreme_words[i] : $urandom();
			send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, word);
		end
		// pushes on a full deque are refused
		send_request(REQ_PUSH_FRONT, $urandom());
		send_request(REQ_PUSH_BACK, $urandom());
		send_request(REQ_POP_FRONT, $urandom());
		send_request(REQ_POP_BACK, $urandom());
		wait_all_results();

		// random part: alternate fill-biased and drain-biased stretches so the deque
		// swings between empty and full and both positions wrap many times
		for (int phase = 0; phase < IDLE_PHASES; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 75;
				end
				1: begin
					tx_idle_pct = 75;
					rx_idle_pct = 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / IDLE_PHASES; n++) begin
				if (bias_left == 0) begin
					filling   = !filling;
					bias_left = $urandom_range(24, 48);
				end
				bias_left--;
				pushing = (($urandom_range(99) < 75) == filling);
				if (pushing)
					req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
				else
					req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
				case ($urandom_range(7))
					0: word = extreme_words[$urandom_range(4)];
					1: word = $urandom_range(15);
					default: word = $urandom();
				endcase
				send_request(req, word);
			end
			wait_all_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d results checked across three idle patterns",
			requests_sent, result_count);
		$display("%0d pushes refused while full, %0d pops refused while empty",
			full_refusals, empty_refusals);
		if (fail_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bdq_chain.sv
rtl/core/bounded_double_ended_queue_unit.sv
test/bdq_result_checker.sv
test/tb.sv
